@@ rtl/patd_pkg.sv @@
package patd_pkg;

  localparam int unsigned PORT_SPACE_DEF = 65536;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned THR_W       = 16;
  localparam int unsigned ELAPSED_W   = 16;
  localparam int unsigned DIST_W      = 17;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ROW_BITS    = 64;
  localparam int unsigned EPOCH_W     = 8;
  localparam int unsigned QUOT_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] SSH_PORT = 16'd22;
  localparam logic [15:0] FTP_PORT = 16'd21;
  localparam logic [15:0] DNS_PORT = 16'd53;

  localparam logic [THR_W-1:0] SSH_THR_RST    = 16'd10;
  localparam logic [THR_W-1:0] FTP_THR_RST    = 16'd15;
  localparam logic [THR_W-1:0] SCAN_THR_RST   = 16'd20;
  localparam logic [THR_W-1:0] DNS_THR_RST    = 16'd100;
  localparam logic [THR_W-1:0] SYN_THR_RST    = 16'd500;
  localparam logic [THR_W-1:0] WINDOW_SEC_RST = 16'd60;

  typedef enum logic [2:0] {
    REG_SSH,
    REG_FTP,
    REG_SCAN,
    REG_DNS,
    REG_SYN,
    REG_WINDOW
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } back_state_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic        syn_bit;
    logic        ack_bit;
  } in_item_t;

  typedef struct packed {
    logic        ssh_alert;
    logic        ftp_alert;
    logic        scan_alert;
    logic        flood_alert;
    logic        dns_alert;
    logic        window_cleared;
    logic [31:0] alert_source_address;
    logic [31:0] alert_dest_address;
    logic [15:0] alert_src_port;
    logic [15:0] alert_dest_port;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0] ssh_thr;
    logic [THR_W-1:0] ftp_thr;
    logic [THR_W-1:0] scan_thr;
    logic [THR_W-1:0] dns_thr;
    logic [THR_W-1:0] syn_thr;
    logic [THR_W-1:0] window_sec;
  } cfg_t;

  typedef struct packed {
    logic is_tick;
    logic hit_ssh;
    logic hit_ftp;
    logic hit_dns;
    logic hit_syn;
  } cls_t;

  typedef struct packed {
    in_item_t          item;
    cls_t              cls;
    logic [QUOT_W-1:0] quot;
  } queue_entry_t;

endpackage

@@ rtl/packet_attack_threshold_detector.sv @@
// Packet attack threshold detector. Each input item is a parsed packet header or a one-second
// tick, and each gives exactly one result item in order. Packets bump the port 22, port 21,
// port 53 and SYN-without-ACK counters and mark their destination port in a seen-port bitmap;
// a counter or the distinct-port count that reaches its threshold raises its alert and clears,
// and once the elapsed seconds pass the window all state clears after that packet. In the back
// end a packet is a bitmap row read, then a row update and write on the single-port bitmap
// memory, and a tick needs no memory access; a 2-entry queue sits in front and a result
// register behind, so input and output stall independently. The bitmap holds PORT_SPACE/64
// rows of 64 bits tagged with an 8-bit epoch, so a bitmap clear is one epoch step; after reset
// and after every 256th bitmap clear a clearing pass writes every row, PORT_SPACE/64 rows
// (1024 by default), and no item is processed meanwhile. Thresholds and the window are written
// over the APB port at byte addresses 0x00 to 0x14.
module packet_attack_threshold_detector import patd_pkg::*; #(
  parameter int unsigned PORT_SPACE = PORT_SPACE_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t         cfg_q;
  logic         cfg_we;
  reg_idx_e     reg_idx;
  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_entry;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ssh_thr    <= SSH_THR_RST;
      cfg_q.ftp_thr    <= FTP_THR_RST;
      cfg_q.scan_thr   <= SCAN_THR_RST;
      cfg_q.dns_thr    <= DNS_THR_RST;
      cfg_q.syn_thr    <= SYN_THR_RST;
      cfg_q.window_sec <= WINDOW_SEC_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SSH:    cfg_q.ssh_thr    <= pwdata[THR_W-1:0];
        REG_FTP:    cfg_q.ftp_thr    <= pwdata[THR_W-1:0];
        REG_SCAN:   cfg_q.scan_thr   <= pwdata[THR_W-1:0];
        REG_DNS:    cfg_q.dns_thr    <= pwdata[THR_W-1:0];
        REG_SYN:    cfg_q.syn_thr    <= pwdata[THR_W-1:0];
        REG_WINDOW: cfg_q.window_sec <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SSH:    prdata = DATA_W'(cfg_q.ssh_thr);
      REG_FTP:    prdata = DATA_W'(cfg_q.ftp_thr);
      REG_SCAN:   prdata = DATA_W'(cfg_q.scan_thr);
      REG_DNS:    prdata = DATA_W'(cfg_q.dns_thr);
      REG_SYN:    prdata = DATA_W'(cfg_q.syn_thr);
      REG_WINDOW: prdata = DATA_W'(cfg_q.window_sec);
      default:    prdata = '0;
    endcase
  end

  patd_front #(
    .PORT_SPACE (PORT_SPACE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_entry_o  (q_entry)
  );

  patd_back #(
    .PORT_SPACE (PORT_SPACE),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/patd_front.sv @@
module patd_front import patd_pkg::*; #(
  parameter int unsigned PORT_SPACE = PORT_SPACE_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  in_item_t     in_item_i,
  output logic         q_valid_o,
  input  logic         q_pop_i,
  output queue_entry_t q_entry_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / PORT_SPACE);

  queue_entry_t      entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push;
  logic [48:0]       prod;
  queue_entry_t      new_entry;

  // quotient of dest_port by the port space, at most one short
  assign prod = 49'(in_item_i.dest_port) * 49'(RECIP);

  always_comb begin
    new_entry.item        = in_item_i;
    new_entry.cls.is_tick = in_item_i.opcode;
    new_entry.cls.hit_ssh = (in_item_i.dest_port == SSH_PORT);
    new_entry.cls.hit_ftp = (in_item_i.dest_port == FTP_PORT);
    new_entry.cls.hit_dns = (in_item_i.dest_port == DNS_PORT);
    new_entry.cls.hit_syn = in_item_i.syn_bit & ~in_item_i.ack_bit;
    new_entry.quot        = prod[47:32];
  end

  assign in_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

@@ rtl/patd_back.sv @@
module patd_back import patd_pkg::*; #(
  parameter int unsigned PORT_SPACE = PORT_SPACE_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         q_valid_i,
  input  queue_entry_t q_entry_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_item_t    out_item_o
);

  localparam int unsigned BIT_W = $clog2(ROW_BITS);
  localparam int unsigned ROWS  = (PORT_SPACE + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int unsigned MEM_W = EPOCH_W + ROW_BITS;

  // each row: epoch tag above the port bits
  logic [MEM_W-1:0] mem [ROWS];

  back_state_e            state_q, state_d;
  logic [ROW_W-1:0]       clr_cnt_q, clr_cnt_d;
  logic [EPOCH_W-1:0]     epoch_q, epoch_d;
  logic [COUNT_BITS-1:0]  ssh_cnt_q, ssh_cnt_d;
  logic [COUNT_BITS-1:0]  ftp_cnt_q, ftp_cnt_d;
  logic [COUNT_BITS-1:0]  dns_cnt_q, dns_cnt_d;
  logic [COUNT_BITS-1:0]  syn_cnt_q, syn_cnt_d;
  logic [DIST_W-1:0]      distinct_q, distinct_d;
  logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;
  in_item_t               work_q;
  cls_t                   work_cls_q;
  logic [ROW_W-1:0]       row_q;
  logic [BIT_W-1:0]       bit_q;
  logic [MEM_W-1:0]       rd_q;

  logic [16:0]            qd, r0, slot_full;
  logic [ROW_W-1:0]       rd_row;
  logic [BIT_W-1:0]       rd_bit;
  logic                   mem_re, mem_we;
  logic [ROW_W-1:0]       mem_waddr;
  logic [MEM_W-1:0]       mem_wdata;
  logic                   out_free;
  logic                   take;
  logic [ROW_BITS-1:0]    row_seen;
  logic                   new_port;
  logic [DIST_W-1:0]      dist_inc;
  logic                   scan_a, win_clr, map_clear;
  logic [COUNT_BITS:0]    ssh_b, ftp_b, dns_b, syn_b;
  logic                   clr_last;

  function automatic logic [COUNT_BITS:0] bump(input logic [COUNT_BITS-1:0] cnt,
                                               input logic [THR_W-1:0] lim);
    logic [COUNT_BITS-1:0] nxt;
    logic                  hit;
    nxt = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + 1'b1;
    hit = (CMP_W'(nxt) >= CMP_W'(lim));
    return {hit, hit ? {COUNT_BITS{1'b0}} : nxt};
  endfunction

  // remainder of dest_port by the port space
  always_comb begin
    qd        = 17'(32'(q_entry_i.quot) * PORT_SPACE);
    r0        = {1'b0, q_entry_i.item.dest_port} - qd;
    slot_full = (r0 >= 17'(PORT_SPACE)) ? r0 - 17'(PORT_SPACE) : r0;
    rd_row    = ROW_W'(slot_full >> BIT_W);
    rd_bit    = slot_full[BIT_W-1:0];
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign clr_last = (clr_cnt_q == ROW_W'(ROWS - 1));

  always_comb begin
    row_seen  = (rd_q[MEM_W-1 -: EPOCH_W] == epoch_q) ? rd_q[ROW_BITS-1:0] : '0;
    new_port  = !row_seen[bit_q];
    dist_inc  = distinct_q + 1'b1;
    scan_a    = new_port && (dist_inc >= DIST_W'(cfg_i.scan_thr));
    win_clr   = (elapsed_q > cfg_i.window_sec);
    map_clear = scan_a || win_clr;
    ssh_b     = bump(ssh_cnt_q, cfg_i.ssh_thr);
    ftp_b     = bump(ftp_cnt_q, cfg_i.ftp_thr);
    dns_b     = bump(dns_cnt_q, cfg_i.dns_thr);
    syn_b     = bump(syn_cnt_q, cfg_i.syn_thr);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i && !q_entry_i.cls.is_tick) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = (map_clear && (epoch_q == '1)) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop_o     = 1'b0;
    take        = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = row_q;
    mem_wdata   = '0;
    clr_cnt_d   = clr_cnt_q;
    epoch_d     = epoch_q;
    ssh_cnt_d   = ssh_cnt_q;
    ftp_cnt_d   = ftp_cnt_q;
    dns_cnt_d   = dns_cnt_q;
    syn_cnt_d   = syn_cnt_q;
    distinct_d  = distinct_q;
    elapsed_d   = elapsed_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.cls.is_tick) begin
            if (out_free) begin
              q_pop_o     = 1'b1;
              elapsed_d   = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
              out_item_d  = '0;
              out_valid_d = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            take    = 1'b1;
            mem_re  = 1'b1;
          end
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_valid_d                     = 1'b1;
          out_item_d.ssh_alert            = work_cls_q.hit_ssh && ssh_b[COUNT_BITS];
          out_item_d.ftp_alert            = work_cls_q.hit_ftp && ftp_b[COUNT_BITS];
          out_item_d.scan_alert           = scan_a;
          out_item_d.flood_alert          = work_cls_q.hit_syn && syn_b[COUNT_BITS];
          out_item_d.dns_alert            = work_cls_q.hit_dns && dns_b[COUNT_BITS];
          out_item_d.window_cleared       = win_clr;
          out_item_d.alert_source_address = work_q.source_address;
          out_item_d.alert_dest_address   = work_q.dest_address;
          out_item_d.alert_src_port       = work_q.src_port;
          out_item_d.alert_dest_port      = work_q.dest_port;
          if (work_cls_q.hit_ssh) ssh_cnt_d = ssh_b[COUNT_BITS-1:0];
          if (work_cls_q.hit_ftp) ftp_cnt_d = ftp_b[COUNT_BITS-1:0];
          if (work_cls_q.hit_dns) dns_cnt_d = dns_b[COUNT_BITS-1:0];
          if (work_cls_q.hit_syn) syn_cnt_d = syn_b[COUNT_BITS-1:0];
          if (new_port) distinct_d = scan_a ? '0 : dist_inc;
          if (new_port && !map_clear) begin
            mem_we    = 1'b1;
            mem_wdata = {epoch_q, row_seen | (ROW_BITS'(1) << bit_q)};
          end
          if (win_clr) begin
            ssh_cnt_d  = '0;
            ftp_cnt_d  = '0;
            dns_cnt_d  = '0;
            syn_cnt_d  = '0;
            distinct_d = '0;
            elapsed_d  = '0;
          end
          if (map_clear) begin
            epoch_d   = (epoch_q == '1) ? '0 : epoch_q + 1'b1;
            clr_cnt_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      epoch_q     <= '0;
      ssh_cnt_q   <= '0;
      ftp_cnt_q   <= '0;
      dns_cnt_q   <= '0;
      syn_cnt_q   <= '0;
      distinct_q  <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      epoch_q     <= epoch_d;
      ssh_cnt_q   <= ssh_cnt_d;
      ftp_cnt_q   <= ftp_cnt_d;
      dns_cnt_q   <= dns_cnt_d;
      syn_cnt_q   <= syn_cnt_d;
      distinct_q  <= distinct_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    if (take) begin
      work_q     <= q_entry_i.item;
      work_cls_q <= q_entry_i.cls;
      row_q      <= rd_row;
      bit_q      <= rd_bit;
    end
  end

  // seen-port bitmap
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[rd_row];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
